[rtl/core/wsd_pkg.sv]
// Shared types and sizing constants for the work-stealing deque core.
package wsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned PTR_SPAN    = 2 * QUEUE_DEPTH;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned PTR_W       = $clog2(PTR_SPAN);
  localparam int unsigned TASK_W      = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = 8 * ((CMD_W + TASK_W + 7) / 8);
  localparam int unsigned OUT_DATA_W  = 8 * ((TASK_W + STATUS_W + 7) / 8);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Slot memory request plus the status decided at accept time.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    status_t           status;
  } slot_req_t;

endpackage

[rtl/core/work_stealing_deque_core.sv]
// Top level of the work-stealing deque core: stream ports, slot RAM, result path.
// Result path: a command's result is registered in stage A (slot RAM access)
//   and then in the output register before it is presented.
// Throughput: one command per cycle unless the output stalls; the pointers update
//   at accept, and the single-port slot RAM serves one read or one write per command.
// A stalled output holds one result plus one in flight before input stalls.
// Reset (rst, synchronous): both pointers and all valid flags clear; slot
//   contents are left as they are and never read before a push writes them.
module work_stealing_deque_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [1:0] cmd, [33:2] task_handle, [39:34] zero
  input  logic [wsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [31:0] task_out, [33:32] status, [39:34] zero
  output logic [wsd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  wsd_pkg::cmd_t                cmd;
  logic [wsd_pkg::TASK_W-1:0]   task_handle;
  logic                         in_accept;
  wsd_pkg::slot_req_t           req;
  logic [wsd_pkg::TASK_W-1:0]   ram_rdata;

  // Stage A: command accepted, RAM access under way.
  logic                         a_valid;
  logic                         a_read;
  wsd_pkg::status_t             a_status;
  logic                         a_move;

  // Output register.
  logic                         out_valid;
  logic [wsd_pkg::TASK_W-1:0]   task_out;
  wsd_pkg::status_t             status;

  assign cmd         = wsd_pkg::cmd_t'(s_axis_tdata[wsd_pkg::CMD_W-1:0]);
  assign task_handle = s_axis_tdata[wsd_pkg::CMD_W +: wsd_pkg::TASK_W];

  // Stage A drains whenever the output register is free or being taken.
  assign a_move        = a_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || a_move;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Pointer state and full/empty decode; pointers advance on accept.
  wsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .cmd    (cmd),
    .req    (req)
  );

  // Task slots. A write at one edge is visible to a read issued the
  // next cycle, so back-to-back push then pop needs no forwarding.
  wsd_ram #(
    .WIDTH (wsd_pkg::TASK_W),
    .DEPTH (wsd_pkg::QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (in_accept && req.we),
    .re    (in_accept && req.re),
    .addr  (req.addr),
    .wdata (task_handle),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_read   <= req.re;
      a_status <= req.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // RAM read data is still the stage A item's value here: a new read
  // issued this cycle lands only at this same edge.
  always_ff @(posedge clk) begin
    if (a_move) begin
      task_out <= a_read ? ram_rdata : '0;
      status   <= a_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(wsd_pkg::OUT_DATA_W - wsd_pkg::TASK_W - wsd_pkg::STATUS_W)'(0),
                          status, task_out};

endmodule

[rtl/core/wsd_ram.sv]
// Generic single-port RAM with registered read data.
module wsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/wsd_ctrl.sv]
// Top/bottom pointer registers and per-command slot access decode.
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  wsd_pkg::cmd_t     cmd,
  output wsd_pkg::slot_req_t req
);

  localparam logic [wsd_pkg::PTR_W-1:0] DEPTH_P =
    wsd_pkg::PTR_W'(wsd_pkg::QUEUE_DEPTH);
  localparam logic [wsd_pkg::PTR_W-1:0] SPAN_M1 =
    wsd_pkg::PTR_W'(wsd_pkg::PTR_SPAN - 1);
  localparam logic [wsd_pkg::PTR_W:0]   SPAN_X =
    (wsd_pkg::PTR_W + 1)'(wsd_pkg::PTR_SPAN);
  localparam logic [wsd_pkg::PTR_W:0]   DEPTH_X =
    (wsd_pkg::PTR_W + 1)'(wsd_pkg::QUEUE_DEPTH);

  logic [wsd_pkg::PTR_W-1:0] top_index, top_index_next;
  logic [wsd_pkg::PTR_W-1:0] bottom_index, bottom_index_next;
  logic [wsd_pkg::PTR_W:0]   diff;
  logic [wsd_pkg::PTR_W:0]   count;
  logic                      is_empty, is_full, is_one;
  logic [wsd_pkg::PTR_W-1:0] bottom_dec, top_inc, bottom_inc;

  function automatic logic [wsd_pkg::PTR_W-1:0] ptr_inc(
    input logic [wsd_pkg::PTR_W-1:0] p
  );
    return (p == SPAN_M1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [wsd_pkg::PTR_W-1:0] ptr_dec(
    input logic [wsd_pkg::PTR_W-1:0] p
  );
    return (p == '0) ? SPAN_M1 : p - 1'b1;
  endfunction

  function automatic logic [wsd_pkg::SLOT_W-1:0] slot_of(
    input logic [wsd_pkg::PTR_W-1:0] p
  );
    logic [wsd_pkg::PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[wsd_pkg::SLOT_W-1:0];
  endfunction

  // occupancy = (bottom - top) mod span
  assign diff     = {1'b0, bottom_index} - {1'b0, top_index};
  assign count    = diff[wsd_pkg::PTR_W] ? diff + SPAN_X : diff;
  assign is_empty = (count == '0);
  assign is_one   = (count == (wsd_pkg::PTR_W + 1)'(1));
  assign is_full  = (count >= DEPTH_X);

  assign bottom_dec = ptr_dec(bottom_index);
  assign bottom_inc = ptr_inc(bottom_index);
  assign top_inc    = ptr_inc(top_index);

  always_comb begin
    req               = '0;
    req.status        = wsd_pkg::ST_DONE;
    top_index_next    = top_index;
    bottom_index_next = bottom_index;
    case (cmd)
      wsd_pkg::CMD_PUSH: begin
        if (is_full) begin
          req.status = wsd_pkg::ST_FULL;
        end else begin
          req.we            = 1'b1;
          req.addr          = slot_of(bottom_index);
          bottom_index_next = bottom_inc;
        end
      end
      wsd_pkg::CMD_POP: begin
        if (is_empty) begin
          req.status = wsd_pkg::ST_EMPTY;
        end else begin
          req.re   = 1'b1;
          req.addr = slot_of(bottom_dec);
          // last task: top catches up, bottom stays
          if (is_one) begin
            top_index_next = bottom_index;
          end else begin
            bottom_index_next = bottom_dec;
          end
        end
      end
      wsd_pkg::CMD_STEAL: begin
        if (is_empty) begin
          req.status = wsd_pkg::ST_EMPTY;
        end else begin
          req.re         = 1'b1;
          req.addr       = slot_of(top_index);
          top_index_next = top_inc;
        end
      end
      default: begin
        req.status = wsd_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_index    <= '0;
      bottom_index <= '0;
    end else if (accept) begin
      top_index    <= top_index_next;
      bottom_index <= bottom_index_next;
    end
  end

endmodule

[sim/deque_scoreboard_pkg.sv]
// Scoreboard class for the deque core: queue-state predictor and result checker.
package deque_scoreboard_pkg;

  import wsd_pkg::*;

  typedef struct packed {
    logic [TASK_W-1:0] handle_out;
    status_t           status;
  } deque_result_t;

  class deque_scoreboard;

    logic [TASK_W-1:0] slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  top_ptr;
    logic [PTR_W-1:0]  bottom_ptr;
    deque_result_t     pending_results [$];
    int unsigned       errors;

    function new();
      top_ptr    = '0;
      bottom_ptr = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Apply one accepted command to the queue image and queue its result.
    function void note_command(cmd_t op, logic [TASK_W-1:0] handle);
      int unsigned   held;
      int unsigned   last_ptr;
      deque_result_t res;
      held = (int'(bottom_ptr) + PTR_SPAN - int'(top_ptr)) % PTR_SPAN;
      res.handle_out = '0;
      res.status     = ST_DONE;
      case (op)
        CMD_PUSH: begin
          if (held >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slots[bottom_ptr % QUEUE_DEPTH] = handle;
            bottom_ptr = PTR_W'((int'(bottom_ptr) + 1) % PTR_SPAN);
          end
        end
        CMD_POP: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
          end else begin
            last_ptr = (int'(bottom_ptr) + PTR_SPAN - 1) % PTR_SPAN;
            res.handle_out = slots[last_ptr % QUEUE_DEPTH];
            // taking the last task collapses both pointers onto bottom
            if (held == 1) top_ptr = bottom_ptr;
            else bottom_ptr = PTR_W'(last_ptr);
          end
        end
        CMD_STEAL: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.handle_out = slots[top_ptr % QUEUE_DEPTH];
            top_ptr = PTR_W'((int'(top_ptr) + 1) % PTR_SPAN);
          end
        end
        default: ;  // unused code: no-op, done with zero handle
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare one accepted output item against the oldest expectation.
    function void check_result(logic [OUT_DATA_W-1:0] data);
      deque_result_t want;
      logic [TASK_W-1:0] got_handle;
      logic [STATUS_W-1:0] got_status;
      got_handle = data[TASK_W-1:0];
      got_status = data[TASK_W +: STATUS_W];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual handle %h status %0d",
                 $time, got_handle, got_status);
        return;
      end
      want = pending_results.pop_front();
      if (got_handle !== want.handle_out) begin
        errors++;
        $display("%0t: handle_out mismatch: expected %h, actual %h",
                 $time, want.handle_out, got_handle);
      end
      if (got_status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got_status);
      end
    endfunction

  endclass

endpackage

[sim/tb.sv]
// Testbench top for work_stealing_deque_core: directed and random command streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;
  import deque_scoreboard_pkg::*;

  // The cycle limit covers the slowest legal item: sender gap, sink stall and core latency.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tready = 1'b0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;

  deque_scoreboard sb;
  bit              idle_en = 1'b1;  // random gaps and stalls allowed
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;

  work_stealing_deque_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sink side: check every accepted item, then pick next tready.
  // Stalls come in random-length bursts; none once idle_en drops.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_en && !rst && $urandom_range(0, 19) == 0) begin
      stall_left    <= $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Mostly random handles, with the all-zero and all-one extremes mixed in.
  function automatic logic [TASK_W-1:0] rand_handle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one command and hold it until accepted; optionally idle after.
  task automatic send_command(cmd_t op, logic [TASK_W-1:0] handle);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - CMD_W - TASK_W){1'b0}}, handle, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(op, handle);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Random command mix; weights in percent, the rest are unused-code no-ops.
  task automatic run_mix(int unsigned n_items, int unsigned push_pct,
                         int unsigned pop_pct, int unsigned steal_pct);
    int unsigned roll;
    cmd_t        op;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = CMD_PUSH;
      else if (roll < push_pct + pop_pct) op = CMD_POP;
      else if (roll < push_pct + pop_pct + steal_pct) op = CMD_STEAL;
      else op = CMD_NOP;
      // handle is don't-care for pop/steal/nop but still randomized
      send_command(op, rand_handle());
    end
  endtask

  // Short directed sequence: empty ring, last-task pop and steal, extremes.
  task automatic run_directed();
    send_command(CMD_POP,   32'hFFFF_FFFF);  // pop on empty
    send_command(CMD_STEAL, 32'h0000_0000);  // steal on empty
    send_command(CMD_NOP,   32'hFFFF_FFFF);  // unused code
    send_command(CMD_PUSH,  32'h0000_0000);
    send_command(CMD_POP,   32'h0000_0000);  // pop of last task
    send_command(CMD_POP,   32'h0000_0000);  // empty again after collapse
    send_command(CMD_PUSH,  32'hFFFF_FFFF);
    send_command(CMD_PUSH,  32'h1234_5678);
    send_command(CMD_PUSH,  32'hA5A5_A5A5);
    send_command(CMD_STEAL, 32'h0000_0000);  // oldest out
    send_command(CMD_POP,   32'hFFFF_FFFF);  // newest out
    send_command(CMD_POP,   32'h0000_0000);  // last task via pop
    send_command(CMD_STEAL, 32'hFFFF_FFFF);  // empty
    send_command(CMD_PUSH,  32'h5A5A_5A5A);
    send_command(CMD_STEAL, 32'h0000_0000);  // last task via steal
    send_command(CMD_POP,   32'h0000_0000);  // empty
    send_command(CMD_NOP,   32'h0000_0000);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    // near-empty churn
    run_mix(80, 40, 25, 25);
    // fill to capacity and keep pushing into the full ring
    run_mix(300, 95, 1, 1);
    // drain mostly from the top
    run_mix(250, 15, 5, 77);
    // refill; bottom pointer wraps past twice the depth
    run_mix(250, 95, 1, 1);
    // tail of the run with no idling on either side
    idle_en = 1'b0;
    run_mix(100, 40, 28, 28);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
